// ===== src/fpbs_pkg.sv =====
// shared constants, microcode word layout and control rom for the binary search block
// no dependencies
package fpbs_pkg;

  localparam int Depth     = 16;
  localparam int DataW     = 32;
  localparam int IdxInW    = 4;
  localparam int PosW      = 4;
  localparam int IdxW      = $clog2(Depth);
  localparam int BndW      = IdxW + 2;
  localparam int NumPasses = $clog2(Depth + 1);
  localparam int CntW      = $clog2(NumPasses);

  // word kinds on the input side
  localparam logic ModeWrite  = 1'b0;
  localparam logic ModeSearch = 1'b1;

  typedef logic [1:0] step_t;

  localparam step_t StepFetch = 2'd0;
  localparam step_t StepPass  = 2'd1;
  localparam step_t StepEmit  = 2'd2;

  typedef enum logic [1:0] {
    CondSearch  = 2'd0,
    CondMore    = 2'd1,
    CondOutFree = 2'd2,
    CondAlways  = 2'd3
  } cond_e;

  typedef struct packed {
    logic  in_rdy;
    logic  init;
    logic  pass;
    logic  emit;
    cond_e cond;
    step_t tgt_t;
    step_t tgt_f;
  } ucode_t;

  typedef struct packed {
    logic search_acc;
    logic more;
    logic out_free;
  } seq_flags_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '{in_rdy: 1'b1, init: 1'b1, pass: 1'b0, emit: 1'b0,
          cond: CondSearch, tgt_t: StepPass, tgt_f: StepFetch};
    unique case (step)
      StepFetch: w = '{in_rdy: 1'b1, init: 1'b1, pass: 1'b0, emit: 1'b0,
                       cond: CondSearch, tgt_t: StepPass, tgt_f: StepFetch};
      StepPass:  w = '{in_rdy: 1'b0, init: 1'b0, pass: 1'b1, emit: 1'b0,
                       cond: CondMore, tgt_t: StepPass, tgt_f: StepEmit};
      StepEmit:  w = '{in_rdy: 1'b0, init: 1'b0, pass: 1'b0, emit: 1'b1,
                       cond: CondOutFree, tgt_t: StepFetch, tgt_f: StepEmit};
      default:   w = '{in_rdy: 1'b0, init: 1'b0, pass: 1'b0, emit: 1'b0,
                       cond: CondAlways, tgt_t: StepFetch, tgt_f: StepFetch};
    endcase
    return w;
  endfunction

endpackage

// ===== src/fpbs_seq.sv =====
// microcode sequencer: step counter, control rom lookup and conditional jumps
// depends on fpbs_pkg
module fpbs_seq import fpbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  seq_flags_t flags_i,
  output ucode_t     ctrl_o
);

  step_t  step_q, step_d;
  ucode_t word;
  logic   take;

  assign word   = ucode_rom(step_q);
  assign ctrl_o = word;

  always_comb begin
    unique case (word.cond)
      CondSearch:  take = flags_i.search_acc;
      CondMore:    take = flags_i.more;
      CondOutFree: take = flags_i.out_free;
      CondAlways:  take = 1'b1;
    endcase
    step_d = take ? word.tgt_t : word.tgt_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepFetch;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== src/fixed_pass_binary_search_top.sv =====
// top level of the fixed-pass binary search block: table, search datapath, result register
// depends on fpbs_pkg and fpbs_seq
//
// channel | direction | handshake               | word
// --------+-----------+-------------------------+---------------------------------------------
// in      | input     | in_valid_i / in_stall_o | mode, entry_index, entry_value, search_key
// out     | output    | out_valid_o/ out_stall_i| hit, position
//
// a write word is taken and gives no result
// a search word steps through accept, NumPasses passes through the shared compare unit,
//   then loading the result register
// the result register frees the input side: a new word is taken while a result waits
// reset clears the table to zero at once (flip-flops), so no clearing pass
// a stalled result holds the emit step until the result register is free
module fixed_pass_binary_search_top import fpbs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    mode_i,
  input  logic [IdxInW-1:0]       entry_index_i,
  input  logic signed [DataW-1:0] entry_value_i,
  input  logic signed [DataW-1:0] search_key_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    hit_o,
  output logic [PosW-1:0]         position_o
);

  ucode_t     ctrl;
  seq_flags_t flags;

  // input handshake
  logic in_acc, search_acc, write_acc;

  // table of sorted entries
  logic signed [DataW-1:0] table_q [Depth];
  logic [31:0]             widx_ext;
  logic                    widx_ok;

  // search datapath
  logic signed [DataW-1:0] key_q;
  logic signed [BndW-1:0]  lo_q, hi_q, mid_q;
  logic signed [BndW:0]    sum;
  logic signed [BndW-1:0]  mid_d;
  logic signed [DataW-1:0] probe;
  logic                    found_q;
  logic [CntW-1:0]         cnt_q;
  logic                    active;

  // result register
  logic                   out_valid_q;
  logic                   hit_q;
  logic [PosW-1:0]        pos_q;
  logic                   out_free;
  logic [PosW+BndW-1:0]   mid_ext;

  fpbs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .ctrl_o (ctrl)
  );

  assign in_stall_o = !ctrl.in_rdy;
  assign in_acc     = in_valid_i && ctrl.in_rdy;
  assign search_acc = in_acc && (mode_i == ModeSearch);
  assign write_acc  = in_acc && (mode_i == ModeWrite);

  assign out_free = !out_valid_q || !out_stall_i;

  assign flags.search_acc = search_acc;
  assign flags.more       = (cnt_q != '0);
  assign flags.out_free   = out_free;

  // write port, out-of-range indexes are dropped
  assign widx_ext = 32'(entry_index_i);
  assign widx_ok  = (widx_ext < 32'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        table_q[i] <= '0;
      end
    end else if (write_acc && widx_ok) begin
      table_q[widx_ext[IdxW-1:0]] <= entry_value_i;
    end
  end

  // midpoint: floor of (lo + hi) / 2 on signed bounds
  assign sum    = {lo_q[BndW-1], lo_q} + {hi_q[BndW-1], hi_q};
  assign mid_d  = sum[BndW:1];
  assign probe  = table_q[mid_d[IdxW-1:0]];
  // a pass only takes effect while nothing is found and the bounds have not crossed
  assign active = !found_q && (hi_q >= lo_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.init && search_acc) begin
      key_q <= search_key_i;
      lo_q  <= '0;
      hi_q  <= BndW'(Depth - 1);
      mid_q <= '0;
    end else if (ctrl.pass && active) begin
      mid_q <= mid_d;
      if (probe < key_q) begin
        lo_q <= mid_d + BndW'(1);
      end else if (probe > key_q) begin
        hi_q <= mid_d - BndW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      cnt_q   <= '0;
    end else if (ctrl.init && search_acc) begin
      found_q <= 1'b0;
      cnt_q   <= CntW'(NumPasses - 1);
    end else if (ctrl.pass) begin
      cnt_q <= cnt_q - CntW'(1);
      if (active && probe == key_q) begin
        found_q <= 1'b1;
      end
    end
  end

  // position carries the low bits of the match index, zero on a miss
  assign mid_ext = {{PosW{1'b0}}, mid_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit && out_free) begin
      hit_q <= found_q;
      pos_q <= found_q ? mid_ext[PosW-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign position_o  = pos_q;

  // a live pass always probes inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pass && active |-> (mid_d >= 0) && (mid_d < BndW'(Depth)))
    else $error("midpoint outside table");

  // the last pass hands over to the emit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pass && cnt_q == '0 |=> ctrl.emit)
    else $error("pass count did not end the search");

  // found only rises on an equal probe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(found_q) |-> $past(ctrl.pass && active && probe == key_q))
    else $error("found set without a match");

  // a miss always reports position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> position_o == '0)
    else $error("nonzero position on a miss");

endmodule
